FILE: hdl/directed_graph_cycle_check_defines.svh
// ---------------------------------------------------------------------------
// Directed graph cycle check: assertion macros
// Shared macros for the concurrent checks in the design modules. The macros
// expect clk_i and rst_ni in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef DIRECTED_GRAPH_CYCLE_CHECK_DEFINES_SVH
`define DIRECTED_GRAPH_CYCLE_CHECK_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define DGCC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define DGCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DGCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/dgcc_pkg.sv
// ---------------------------------------------------------------------------
// Directed graph cycle check: shared package
// Sizes, opcodes, controller states, command and status bundles, and the
// mask and priority-encoder helpers used by the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dgcc_pkg;

  // Graph size and derived widths.
  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int CFG_W        = 7;
  localparam int OP_W         = 2;
  localparam int STK_W        = VTX_W + CNT_W;

  // Opcodes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_CHECK = 2'd2
  } opcode_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_ROOT,
    ST_ROW_RD,
    ST_SCAN,
    ST_POP_WAIT,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_rd;
    logic add_wr;
    logic clear_graph;
    logic chk_init;
    logic root_start;
    logic row_rd;
    logic scan_skip;
    logic scan_push;
    logic scan_pop;
    logic pop_load;
    logic set_res;
    logic res_val;
    logic res_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_e in_op;
    logic    add_ok;
    logic    root_found;
    logic    scan_found;
    logic    scan_hit;
    logic    scan_can_push;
    logic    depth_one;
    logic    out_free;
  } sts_t;

  // Result of a lowest-set-bit search.
  typedef struct packed {
    logic             found;
    logic [VTX_W-1:0] idx;
  } pick_t;

  // Mask with every bit below k set.
  function automatic logic [MAX_VERTICES-1:0] low_mask(input logic [CNT_W-1:0] k);
    logic [MAX_VERTICES-1:0] m;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = (i < int'(k));
    end
    return m;
  endfunction

  // Priority encoder: index of the lowest set bit.
  function automatic pick_t first_set(input logic [MAX_VERTICES-1:0] vec);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        p.found = 1'b1;
        p.idx   = VTX_W'(i);
      end
    end
    return p;
  endfunction

endpackage

FILE: hdl/dgcc_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data. The read
// data holds its value while no read is issued.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dgcc_ctrl.sv
// ---------------------------------------------------------------------------
// Directed graph cycle check: controller
// Sequences edge adds, graph clears and the depth-first search, and hands
// the result to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgcc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dgcc_pkg::sts_t sts_i,
  output dgcc_pkg::cmd_t cmd_o
);

  dgcc_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dgcc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Items are taken only while no operation is in progress.
  assign in_stall_o = (state_q != dgcc_pkg::ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      dgcc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.in_op)
            dgcc_pkg::OP_ADD: begin
              if (sts_i.add_ok) begin
                cmd_o.add_rd = 1'b1;
                state_d      = dgcc_pkg::ST_ADD_WR;
              end
            end
            dgcc_pkg::OP_CLEAR: begin
              cmd_o.clear_graph = 1'b1;
            end
            dgcc_pkg::OP_CHECK: begin
              cmd_o.chk_init = 1'b1;
              state_d        = dgcc_pkg::ST_ROOT;
            end
            default: begin
              state_d = dgcc_pkg::ST_IDLE;
            end
          endcase
        end
      end
      dgcc_pkg::ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = dgcc_pkg::ST_IDLE;
      end
      dgcc_pkg::ST_ROOT: begin
        // Start a new tree at the lowest unvisited vertex, or finish clean.
        if (sts_i.root_found) begin
          cmd_o.root_start = 1'b1;
          state_d          = dgcc_pkg::ST_ROW_RD;
        end else begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_val = 1'b0;
          state_d       = dgcc_pkg::ST_DONE;
        end
      end
      dgcc_pkg::ST_ROW_RD: begin
        cmd_o.row_rd = 1'b1;
        state_d      = dgcc_pkg::ST_SCAN;
      end
      dgcc_pkg::ST_SCAN: begin
        if (!sts_i.scan_found) begin
          cmd_o.scan_pop = 1'b1;
          state_d        = sts_i.depth_one ? dgcc_pkg::ST_ROOT : dgcc_pkg::ST_POP_WAIT;
        end else if (sts_i.scan_hit) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_val = 1'b1;
          state_d       = dgcc_pkg::ST_DONE;
        end else if (sts_i.scan_can_push) begin
          cmd_o.scan_push = 1'b1;
          state_d         = dgcc_pkg::ST_ROW_RD;
        end else begin
          cmd_o.scan_skip = 1'b1;
        end
      end
      dgcc_pkg::ST_POP_WAIT: begin
        cmd_o.pop_load = 1'b1;
        state_d        = dgcc_pkg::ST_ROW_RD;
      end
      dgcc_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = dgcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dgcc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/dgcc_dp.sv
// ---------------------------------------------------------------------------
// Directed graph cycle check: datapath
// Adjacency rows in RAM with per-row valid bits, visited and on-path marks,
// the search stack in RAM with its top held in registers, the row scan
// encoder, and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "directed_graph_cycle_check_defines.svh"

module dgcc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [dgcc_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [dgcc_pkg::OP_W-1:0]     opcode_i,
  input  logic [dgcc_pkg::VTX_W-1:0]    from_vertex_i,
  input  logic [dgcc_pkg::VTX_W-1:0]    to_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          cycle_found_o,
  input  dgcc_pkg::cmd_t                cmd_i,
  output dgcc_pkg::sts_t                sts_o
);

  localparam int NV = dgcc_pkg::MAX_VERTICES;
  localparam int VW = dgcc_pkg::VTX_W;
  localparam int CW = dgcc_pkg::CNT_W;

  // Control state, set at reset: the vertex count to the graph size, the rest cleared.
  logic [dgcc_pkg::CFG_W-1:0] vcount_q, vcount_d;
  logic [NV-1:0]              row_vld_q, row_vld_d;
  logic [NV-1:0]              visited_q, visited_d;
  logic [NV-1:0]              on_path_q, on_path_d;
  logic [CW-1:0]              depth_q, depth_d;
  logic                       out_valid_q, out_valid_d;

  // Payload registers.
  logic [VW-1:0]              from_q, from_d;
  logic [VW-1:0]              to_q, to_d;
  logic [VW-1:0]              cur_v_q, cur_v_d;
  logic [CW-1:0]              cur_w_q, cur_w_d;
  logic                       rd_vld_q, rd_vld_d;
  logic                       res_q, res_d;
  logic                       cycle_found_q, cycle_found_d;

  // Memory ports.
  logic                       adj_we, adj_re;
  logic [VW-1:0]              adj_raddr;
  logic [NV-1:0]              adj_wdata, adj_rdata;
  logic                       stk_we, stk_re;
  logic [VW-1:0]              stk_waddr, stk_raddr;
  logic [dgcc_pkg::STK_W-1:0] stk_wdata, stk_rdata;

  // Search helpers.
  logic [CW-1:0]              n_act;
  logic [NV-1:0]              row_eff;
  logic [NV-1:0]              scan_cand;
  dgcc_pkg::pick_t            scan_pick;
  dgcc_pkg::pick_t            root_pick;
  logic [CW-1:0]              next_w;

  // Active vertex count, saturated at the graph size.
  assign n_act = (int'(vcount_q) > NV) ? CW'(NV) : CW'(vcount_q);

  // A row that was never written since the last clear reads as empty.
  assign row_eff = rd_vld_q ? adj_rdata : '0;

  // Edges from the current vertex at or after the scan position, inside the
  // active range.
  assign scan_cand = row_eff & dgcc_pkg::low_mask(n_act) & ~dgcc_pkg::low_mask(cur_w_q);
  assign scan_pick = dgcc_pkg::first_set(scan_cand);
  assign next_w    = CW'(scan_pick.idx) + CW'(1);

  // Lowest active vertex not yet visited.
  assign root_pick = dgcc_pkg::first_set(~visited_q & dgcc_pkg::low_mask(n_act));

  // Status bundle.
  always_comb begin
    sts_o.in_op         = dgcc_pkg::opcode_e'(opcode_i);
    sts_o.add_ok        = (CW'(from_vertex_i) < n_act) && (CW'(to_vertex_i) < n_act);
    sts_o.root_found    = root_pick.found;
    sts_o.scan_found    = scan_pick.found;
    sts_o.scan_hit      = on_path_q[scan_pick.idx];
    sts_o.scan_can_push = !visited_q[scan_pick.idx] && (depth_q < CW'(NV));
    sts_o.depth_one     = (depth_q == CW'(1));
    sts_o.out_free      = !out_valid_q || !out_stall_i;
  end

  // Adjacency RAM access.
  assign adj_re    = cmd_i.add_rd || cmd_i.row_rd;
  assign adj_raddr = cmd_i.add_rd ? from_vertex_i : cur_v_q;
  assign adj_we    = cmd_i.add_wr;
  assign adj_wdata = row_eff | ({{(NV - 1){1'b0}}, 1'b1} << to_q);

  // Stack RAM access: entries below the top; the top lives in cur_v/cur_w.
  assign stk_we    = cmd_i.scan_push;
  assign stk_waddr = VW'(depth_q - CW'(1));
  assign stk_wdata = {cur_v_q, next_w};
  assign stk_re    = cmd_i.scan_pop;
  assign stk_raddr = VW'(depth_q - CW'(2));

  // Next-state logic of the datapath registers.
  always_comb begin
    vcount_d      = vcount_q;
    row_vld_d     = row_vld_q;
    visited_d     = visited_q;
    on_path_d     = on_path_q;
    depth_d       = depth_q;
    out_valid_d   = out_valid_q;
    from_d        = from_q;
    to_d          = to_q;
    cur_v_d       = cur_v_q;
    cur_w_d       = cur_w_q;
    rd_vld_d      = rd_vld_q;
    res_d         = res_q;
    cycle_found_d = cycle_found_q;

    if (cfg_valid_i) begin
      vcount_d = cfg_data_i;
    end

    // Edge add: latch endpoints, then write back the row with the new bit.
    if (cmd_i.add_rd) begin
      from_d = from_vertex_i;
      to_d   = to_vertex_i;
    end
    if (adj_re) begin
      rd_vld_d = row_vld_q[adj_raddr];
    end
    if (cmd_i.add_wr) begin
      row_vld_d[from_q] = 1'b1;
    end
    if (cmd_i.clear_graph) begin
      row_vld_d = '0;
    end

    // Search bookkeeping.
    if (cmd_i.chk_init) begin
      visited_d = '0;
      on_path_d = '0;
      depth_d   = '0;
    end
    if (cmd_i.root_start) begin
      visited_d[root_pick.idx] = 1'b1;
      on_path_d[root_pick.idx] = 1'b1;
      cur_v_d                  = root_pick.idx;
      cur_w_d                  = '0;
      depth_d                  = CW'(1);
    end
    if (cmd_i.scan_skip) begin
      cur_w_d = next_w;
    end
    if (cmd_i.scan_push) begin
      visited_d[scan_pick.idx] = 1'b1;
      on_path_d[scan_pick.idx] = 1'b1;
      cur_v_d                  = scan_pick.idx;
      cur_w_d                  = '0;
      depth_d                  = depth_q + CW'(1);
    end
    if (cmd_i.scan_pop) begin
      on_path_d[cur_v_q] = 1'b0;
      depth_d            = depth_q - CW'(1);
    end
    if (cmd_i.pop_load) begin
      cur_v_d = stk_rdata[dgcc_pkg::STK_W-1:CW];
      cur_w_d = stk_rdata[CW-1:0];
    end

    // Result hand-off to the output register.
    if (cmd_i.set_res) begin
      res_d = cmd_i.res_val;
    end
    if (cmd_i.res_load) begin
      out_valid_d   = 1'b1;
      cycle_found_d = res_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= dgcc_pkg::CFG_W'(NV);
      row_vld_q   <= '0;
      visited_q   <= '0;
      on_path_q   <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vcount_q    <= vcount_d;
      row_vld_q   <= row_vld_d;
      visited_q   <= visited_d;
      on_path_q   <= on_path_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    from_q        <= from_d;
    to_q          <= to_d;
    cur_v_q       <= cur_v_d;
    cur_w_q       <= cur_w_d;
    rd_vld_q      <= rd_vld_d;
    res_q         <= res_d;
    cycle_found_q <= cycle_found_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cycle_found_o = cycle_found_q;

  // Adjacency rows, one word per source vertex.
  dgcc_ram #(
    .WIDTH (NV),
    .DEPTH (NV)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (from_q),
    .wdata_i (adj_wdata),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  // Search stack: vertex and resume scan position.
  dgcc_ram #(
    .WIDTH (dgcc_pkg::STK_W),
    .DEPTH (NV)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Every vertex on the current path is on the stack, and vice versa.
  `DGCC_ASSERT_ALWAYS(a_path_matches_depth, $countones(on_path_q) == int'(depth_q), "on-path marks disagree with stack depth")
  // A vertex on the path has always been visited.
  `DGCC_ASSERT_ALWAYS(a_path_visited, (on_path_q & ~visited_q) == '0, "on-path vertex not marked visited")
  // The stack never grows past the graph size.
  `DGCC_ASSERT_ALWAYS(a_depth_bound, depth_q <= CW'(NV), "search stack overflow")
  // A push only descends into a found, unvisited vertex.
  `DGCC_ASSERT_SAME(a_push_fresh, cmd_i.scan_push, scan_pick.found && !visited_q[scan_pick.idx], "push into visited vertex")
  // A new check starts from clean marks.
  `DGCC_ASSERT_NEXT(a_init_clears, cmd_i.chk_init, visited_q == '0 && depth_q == '0, "marks not cleared at check start")

endmodule

FILE: hdl/directed_graph_cycle_check.sv
// An edge add reads the source row, then writes it back with the new bit; an add with an
// endpoint outside the active count is ignored. A clear or an unused opcode needs no further
// state. A check searches depth-first; its result waits while out_stall_i holds it. A root costs
// a root step, a row read and a final scan; any other vertex a row read, a final scan and a
// stack reload; each edge a priority-encoded scan step. Throughput: one item at a time, no overlap.
// Reset: asynchronous, active low; empties the graph, clears marks, output, count to 64.
// ---------------------------------------------------------------------------
// Directed graph cycle check: top level
// Stores a directed graph as an adjacency bit matrix and answers whether it
// holds a directed cycle, by depth-first search with an explicit stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module directed_graph_cycle_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write channel.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [dgcc_pkg::CFG_W-1:0] cfg_data_i,
  // Input items.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [dgcc_pkg::OP_W-1:0]  opcode_i,
  input  logic [dgcc_pkg::VTX_W-1:0] from_vertex_i,
  input  logic [dgcc_pkg::VTX_W-1:0] to_vertex_i,
  // Result items.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       cycle_found_o
);

  dgcc_pkg::cmd_t cmd;
  dgcc_pkg::sts_t sts;

  // The count register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Operation sequencer.
  dgcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Graph storage and search datapath.
  dgcc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (opcode_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cycle_found_o (cycle_found_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
